[src/gpx_pkg.sv]
`default_nettype none

package gpx_pkg;

   localparam int unsigned NumRegs = 8;

   // Event codes carried in the kind field of a request beat.
   typedef enum logic [2:0] {
      KIND_CMD       = 3'd0,
      KIND_WRITE     = 3'd1,
      KIND_READ      = 3'd2,
      KIND_PINS      = 3'd3,
      KIND_RESET_PIN = 3'd4
   } kind_type;

   // Register indexes addressed by the pointer.
   localparam logic [2:0] REG_IN0   = 3'd0;
   localparam logic [2:0] REG_IN1   = 3'd1;
   localparam logic [2:0] REG_OUT0  = 3'd2;
   localparam logic [2:0] REG_OUT1  = 3'd3;
   localparam logic [2:0] REG_INV0  = 3'd4;
   localparam logic [2:0] REG_INV1  = 3'd5;
   localparam logic [2:0] REG_CONF0 = 3'd6;
   localparam logic [2:0] REG_CONF1 = 3'd7;

   localparam logic [15:0] ALL_ONES   = 16'hffff;
   localparam logic [15:0] ALL_ZEROES = 16'h0000;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] pin_levels;
   } item_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        ack;
      logic        int_level;
      logic [15:0] pin_drive;
      logic [15:0] pin_output_enable;
   } result_type;

   function automatic logic [7:0] get_byte(input logic [15:0] word, input logic port);
      return port ? word[15:8] : word[7:0];
   endfunction

   function automatic logic [15:0] put_byte(input logic [15:0] word, input logic port,
                                            input logic [7:0] value);
      return port ? {value, word[7:0]} : {word[15:8], value};
   endfunction

endpackage

`default_nettype wire

[src/gpx_req_if.sv]
`default_nettype none

interface gpx_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  data_byte;
   logic [15:0] pin_levels;

   modport source (output valid, output kind, output data_byte, output pin_levels,
                   input ready);
   modport sink (input valid, input kind, input data_byte, input pin_levels,
                 output ready);
endinterface

`default_nettype wire

[src/gpx_rsp_if.sv]
`default_nettype none

interface gpx_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        ack;
   logic        int_level;
   logic [15:0] pin_drive;
   logic [15:0] pin_output_enable;

   modport source (output valid, output read_data, output ack, output int_level,
                   output pin_drive, output pin_output_enable, input ready);
   modport sink (input valid, input read_data, input ack, input int_level,
                 input pin_drive, input pin_output_enable, output ready);
endinterface

`default_nettype wire

[src/gpio_expander_register_block.sv]
`default_nettype none

// Register file of a 16-pin, two-port GPIO expander. Each request beat is one
// bus event (command byte, write data byte, read byte), a change of the
// external pin levels, or a falling edge on the reset pin; each request gives
// exactly one response beat with the read byte, the ack, the interrupt pin
// level (0 = asserted) and the pin drive and output enable after the event.
// A beat is registered at the input, then the register update runs as
// combinational logic and lands in the response register; a new request is
// taken every cycle (one beat per clock) as long as the response side keeps
// taking beats. The response register frees as it is read, so input and
// output stall only together when rsp_bus.ready is low.
// Pins switched to output copy their output bit into the input register.
module gpio_expander_register_block (
   input  wire logic clock,
   input  wire logic reset,
   gpx_req_if.sink   req_bus,
   gpx_rsp_if.source rsp_bus
);
   import gpx_pkg::*;

   logic       stage_valid;
   item_type   stage_item;
   logic       advance;
   result_type step_result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   // Move the held beat on when the response register is empty or being read.
   assign advance = stage_valid && (!rsp_valid_ff || rsp_bus.ready);

   gpx_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   gpx_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_fire (advance),
      .item      (stage_item),
      .result    (step_result)
   );

   // Hold the response until taken; load a fresh one on each advance.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.read_data         = rsp_data_ff.read_data;
   assign rsp_bus.ack               = rsp_data_ff.ack;
   assign rsp_bus.int_level         = rsp_data_ff.int_level;
   assign rsp_bus.pin_drive         = rsp_data_ff.pin_drive;
   assign rsp_bus.pin_output_enable = rsp_data_ff.pin_output_enable;

   drive_only_outputs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff.pin_drive & ~rsp_data_ff.pin_output_enable) == ALL_ZEROES))
      else $error("pin driven while configured as input");

   read_data_needs_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.read_data != 8'h00) |-> rsp_data_ff.ack)
      else $error("read data without ack");

   stalled_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid && !advance) |=> stage_valid)
      else $error("held request beat lost");

endmodule

`default_nettype wire

[src/gpx_in_stage.sv]
`default_nettype none

module gpx_in_stage (
   input  wire logic         clock,
   input  wire logic         reset,
   gpx_req_if.sink           req_bus,
   input  wire logic         advance,
   output logic              stage_valid,
   output gpx_pkg::item_type stage_item
);
   import gpx_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     take;

   // Take a new beat when empty or when the held one moves on.
   assign req_bus.ready = !valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.kind       <= kind_type'(req_bus.kind);
         item_ff.data_byte  <= req_bus.data_byte;
         item_ff.pin_levels <= req_bus.pin_levels;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

`default_nettype wire

[src/gpx_core.sv]
`default_nettype none

module gpx_core (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step_fire,
   input  gpx_pkg::item_type   item,
   output gpx_pkg::result_type result
);
   import gpx_pkg::*;

   logic [15:0] inp_ff, inp_in;
   logic [15:0] outp_ff, outp_in;
   logic [15:0] inv_ff, inv_in;
   logic [15:0] conf_ff, conf_in;
   logic [7:0]  ptr_ff, ptr_in;
   logic        stopped_ff, stopped_in;
   logic        int_level_ff, int_level_in;
   logic        int_port_ff, int_port_in;
   logic [15:0] saved_ff, saved_in;
   logic [15:0] ext_ff, ext_in;

   logic        reg_known;
   logic        port;
   logic [7:0]  reg_rd;
   logic [7:0]  chg_byte;
   logic [7:0]  outs;
   logic [7:0]  to_in;
   logic [7:0]  to_out;
   logic [7:0]  in_byte;
   logic [15:0] pin_chg;
   logic        check;
   logic [7:0]  rd;
   logic        ack;

   assign reg_known = (ptr_ff[7:3] == 5'd0);
   assign port      = ptr_ff[0];

   always_comb begin
      case (ptr_ff[2:0])
         REG_IN0:   reg_rd = inp_ff[7:0];
         REG_IN1:   reg_rd = inp_ff[15:8];
         REG_OUT0:  reg_rd = outp_ff[7:0];
         REG_OUT1:  reg_rd = outp_ff[15:8];
         REG_INV0:  reg_rd = inv_ff[7:0];
         REG_INV1:  reg_rd = inv_ff[15:8];
         REG_CONF0: reg_rd = conf_ff[7:0];
         REG_CONF1: reg_rd = conf_ff[15:8];
         default:   reg_rd = 8'h00;
      endcase
   end

   always_comb begin
      inp_in       = inp_ff;
      outp_in      = outp_ff;
      inv_in       = inv_ff;
      conf_in      = conf_ff;
      ptr_in       = ptr_ff;
      stopped_in   = stopped_ff;
      int_level_in = int_level_ff;
      int_port_in  = int_port_ff;
      saved_in     = saved_ff;
      ext_in       = ext_ff;
      chg_byte     = reg_rd ^ item.data_byte;
      outs         = chg_byte & ~get_byte(conf_ff, port);
      to_in        = chg_byte & item.data_byte;
      to_out       = chg_byte & ~item.data_byte;
      in_byte      = get_byte(inp_ff, port);
      pin_chg      = (item.pin_levels ^ ext_ff) & conf_ff;
      check        = 1'b0;
      rd           = 8'h00;
      ack          = 1'b0;

      case (item.kind)
         KIND_CMD: begin
            ptr_in     = item.data_byte;
            stopped_in = (item.data_byte[7:3] != 5'd0);
            ack        = 1'b1;
         end
         KIND_WRITE: begin
            if (!stopped_ff) begin
               if (reg_known && (ptr_ff[2:1] != 2'b00)) begin
                  if (ptr_ff[2:0] inside {REG_OUT0, REG_OUT1}) begin
                     // Output pins whose bit changes mirror it into the input register.
                     in_byte = (in_byte & ~outs) | (item.data_byte & outs);
                     inp_in  = put_byte(inp_ff, port, in_byte);
                     outp_in = put_byte(outp_ff, port, item.data_byte);
                  end else if (ptr_ff[2:0] inside {REG_INV0, REG_INV1}) begin
                     inv_in = put_byte(inv_ff, port, item.data_byte);
                  end else begin
                     // New inputs load the pin level, new outputs the output bit.
                     in_byte = (in_byte & ~to_in) | (get_byte(ext_ff, port) & to_in);
                     in_byte = (in_byte & ~to_out) | (get_byte(outp_ff, port) & to_out);
                     inp_in  = put_byte(inp_ff, port, in_byte);
                     conf_in = put_byte(conf_ff, port, item.data_byte);
                  end
                  ptr_in = {ptr_ff[7:1], ~ptr_ff[0]};
                  ack    = 1'b1;
               end else begin
                  stopped_in = 1'b1;
               end
            end
         end
         KIND_READ: begin
            if (reg_known) begin
               rd = reg_rd;
               if (ptr_ff[2:1] == 2'b00) begin
                  if (int_port_ff == port) begin
                     int_level_in = 1'b1;
                  end
                  rd = reg_rd ^ get_byte(inv_ff, port);
               end
               ack    = 1'b1;
               ptr_in = {ptr_ff[7:1], ~ptr_ff[0]};
            end
         end
         KIND_PINS: begin
            ext_in = item.pin_levels;
            if (pin_chg != ALL_ZEROES) begin
               check = ((pin_chg & (pin_chg - 16'd1)) != ALL_ZEROES);
               if (int_level_ff) begin
                  int_level_in = 1'b0;
                  saved_in     = inp_ff;
                  int_port_in  = (pin_chg[7:0] == 8'h00);
               end else begin
                  check = 1'b1;
               end
               inp_in = (inp_ff & ~pin_chg) | (item.pin_levels & pin_chg);
               if (check && (item.pin_levels == saved_in)) begin
                  int_level_in = 1'b1;
               end
            end
         end
         KIND_RESET_PIN: begin
            inp_in       = ext_ff;
            outp_in      = ALL_ONES;
            inv_in       = ALL_ZEROES;
            conf_in      = ALL_ONES;
            int_level_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign result.read_data         = rd;
   assign result.ack               = ack;
   assign result.int_level         = int_level_in;
   assign result.pin_output_enable = ~conf_in;
   assign result.pin_drive         = outp_in & ~conf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         inp_ff       <= ALL_ONES;
         outp_ff      <= ALL_ONES;
         inv_ff       <= ALL_ZEROES;
         conf_ff      <= ALL_ONES;
         ptr_ff       <= 8'h00;
         stopped_ff   <= 1'b0;
         int_level_ff <= 1'b1;
         int_port_ff  <= 1'b0;
         saved_ff     <= ALL_ZEROES;
         ext_ff       <= ALL_ONES;
      end else if (step_fire) begin
         inp_ff       <= inp_in;
         outp_ff      <= outp_in;
         inv_ff       <= inv_in;
         conf_ff      <= conf_in;
         ptr_ff       <= ptr_in;
         stopped_ff   <= stopped_in;
         int_level_ff <= int_level_in;
         int_port_ff  <= int_port_in;
         saved_ff     <= saved_in;
         ext_ff       <= ext_in;
      end
   end

   cmd_sets_stop: assert property (@(posedge clock) disable iff (reset)
      (step_fire && item.kind == KIND_CMD) |=> (stopped_ff == (ptr_ff[7:3] != 5'd0)))
      else $error("stop flag disagrees with commanded pointer");

   reset_pin_defaults: assert property (@(posedge clock) disable iff (reset)
      (step_fire && item.kind == KIND_RESET_PIN) |=>
         (int_level_ff && conf_ff == ALL_ONES && inv_ff == ALL_ZEROES))
      else $error("reset pin did not restore defaults");

   idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !step_fire |=> ($stable(ptr_ff) && $stable(inp_ff) && $stable(int_level_ff)))
      else $error("state moved without a step");

endmodule

`default_nettype wire

[sim/gpx_register_checker.sv]
`default_nettype none

module gpx_register_checker (
   input  wire logic   clock,
   input  wire logic   reset,
   gpx_req_if          req_bus,
   gpx_rsp_if          rsp_bus,
   output int unsigned mismatch_count,
   output int unsigned pending_beats,
   output int unsigned checked_beats
);
   timeunit 1ns;
   timeprecision 1ps;
   import gpx_pkg::*;

   logic [7:0]  reg_file [NumRegs];
   logic [7:0]  pointer;
   logic        writes_stopped;
   logic        irq_n;
   logic        irq_port;
   logic [15:0] irq_snapshot;
   logic [15:0] pin_seen;

   result_type  awaited_status [$];

   function automatic logic [15:0] input_word();
      return {reg_file[REG_IN1], reg_file[REG_IN0]};
   endfunction

   function automatic void restore_defaults();
      reg_file[REG_OUT0]  = 8'hff;
      reg_file[REG_OUT1]  = 8'hff;
      reg_file[REG_INV0]  = 8'h00;
      reg_file[REG_INV1]  = 8'h00;
      reg_file[REG_CONF0] = 8'hff;
      reg_file[REG_CONF1] = 8'hff;
      irq_n = 1'b1;
   endfunction

   // Store a data byte at the pointer; 0 when the register takes no writes.
   function automatic bit store_data_byte(input logic [7:0] value);
      logic       port;
      logic [2:0] idx;
      logic [7:0] flipped;
      logic [7:0] outs;
      logic [7:0] ext;
      logic [7:0] to_in;
      logic [7:0] to_out;
      logic [7:0] pins;
      if (pointer >= NumRegs || pointer[2:0] < REG_OUT0)
         return 1'b0;
      idx = pointer[2:0];
      port = pointer[0];
      flipped = reg_file[idx] ^ value;
      pins = reg_file[port ? REG_IN1 : REG_IN0];
      if (idx < REG_INV0) begin
         outs = flipped & ~reg_file[port ? REG_CONF1 : REG_CONF0];
         pins = (pins & ~outs) | (value & outs);
      end else if (idx >= REG_CONF0) begin
         ext = port ? pin_seen[15:8] : pin_seen[7:0];
         to_in = flipped & value;
         to_out = flipped & ~value;
         pins = (pins & ~to_in) | (ext & to_in);
         pins = (pins & ~to_out) | (reg_file[port ? REG_OUT1 : REG_OUT0] & to_out);
      end
      reg_file[port ? REG_IN1 : REG_IN0] = pins;
      reg_file[idx] = value;
      return 1'b1;
   endfunction

   // Advance the expander by one event and give its status afterwards.
   function automatic result_type apply_bus_event(input item_type beat);
      result_type  status;
      logic [15:0] dir_in;
      logic [15:0] changed;
      logic [15:0] merged;
      logic [15:0] enables;
      bit          recheck;
      status = '0;
      case (beat.kind)
         KIND_CMD: begin
            pointer = beat.data_byte;
            writes_stopped = (beat.data_byte >= NumRegs);
            status.ack = 1'b1;
         end
         KIND_WRITE: begin
            if (!writes_stopped) begin
               if (store_data_byte(beat.data_byte)) begin
                  pointer = pointer ^ 8'h01;
                  status.ack = 1'b1;
               end else begin
                  writes_stopped = 1'b1;
               end
            end
         end
         KIND_READ: begin
            if (pointer < NumRegs) begin
               status.read_data = reg_file[pointer[2:0]];
               if (pointer[2:0] < REG_OUT0) begin
                  if (irq_port == pointer[0])
                     irq_n = 1'b1;
                  status.read_data ^= reg_file[pointer[0] ? REG_INV1 : REG_INV0];
               end
               status.ack = 1'b1;
               pointer = pointer ^ 8'h01;
            end
         end
         KIND_PINS: begin
            dir_in = {reg_file[REG_CONF1], reg_file[REG_CONF0]};
            changed = (beat.pin_levels ^ pin_seen) & dir_in;
            pin_seen = beat.pin_levels;
            if (changed != ALL_ZEROES) begin
               recheck = (changed & (changed - 16'd1)) != ALL_ZEROES;
               if (irq_n) begin
                  irq_n = 1'b0;
                  irq_snapshot = input_word();
                  irq_port = (changed[7:0] == 8'h00);
               end else begin
                  recheck = 1'b1;
               end
               merged = (input_word() & ~changed) | (beat.pin_levels & changed);
               reg_file[REG_IN0] = merged[7:0];
               reg_file[REG_IN1] = merged[15:8];
               if (recheck && beat.pin_levels == irq_snapshot)
                  irq_n = 1'b1;
            end
         end
         KIND_RESET_PIN: begin
            reg_file[REG_IN0] = pin_seen[7:0];
            reg_file[REG_IN1] = pin_seen[15:8];
            restore_defaults();
         end
         default: ;
      endcase
      enables = ~{reg_file[REG_CONF1], reg_file[REG_CONF0]};
      status.int_level = irq_n;
      status.pin_output_enable = enables;
      status.pin_drive = {reg_file[REG_OUT1], reg_file[REG_OUT0]} & enables;
      return status;
   endfunction

   function automatic void note_failure(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s", $realtime, what);
   endfunction

   always @(posedge clock) begin : watch
      result_type seen;
      result_type wanted;
      result_type fresh;
      item_type   beat;
      if (reset) begin
         reg_file[REG_IN0] = 8'hff;
         reg_file[REG_IN1] = 8'hff;
         restore_defaults();
         pointer = 8'h00;
         writes_stopped = 1'b0;
         irq_port = 1'b0;
         irq_snapshot = ALL_ZEROES;
         pin_seen = ALL_ONES;
         awaited_status.delete();
         mismatch_count = 0;
         checked_beats = 0;
      end else begin
         // Compare first: a response never belongs to a request of the same edge.
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen = {rsp_bus.read_data, rsp_bus.ack, rsp_bus.int_level,
                    rsp_bus.pin_drive, rsp_bus.pin_output_enable};
            if (awaited_status.size() == 0) begin
               note_failure($sformatf("response beat with nothing outstanding: %h", seen));
            end else begin
               wanted = awaited_status.pop_front();
               checked_beats++;
               if (seen.read_data !== wanted.read_data || seen.ack !== wanted.ack ||
                   seen.int_level !== wanted.int_level ||
                   seen.pin_drive !== wanted.pin_drive ||
                   seen.pin_output_enable !== wanted.pin_output_enable)
                  note_failure($sformatf({"beat %0d: expected rd %h ack %b int %b ",
                     "drive %h oe %h, got rd %h ack %b int %b drive %h oe %h"},
                     checked_beats, wanted.read_data, wanted.ack, wanted.int_level,
                     wanted.pin_drive, wanted.pin_output_enable, seen.read_data,
                     seen.ack, seen.int_level, seen.pin_drive, seen.pin_output_enable));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            beat = {kind_type'(req_bus.kind), req_bus.data_byte, req_bus.pin_levels};
            fresh = apply_bus_event(beat);
            awaited_status.insert(awaited_status.size(), fresh);
         end
      end
      pending_beats = awaited_status.size();
   end

endmodule

`default_nettype wire

[sim/tb.sv]
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gpx_pkg::*;

   logic        clock = 1'b0;
   logic        reset;

   gpx_req_if   req_bus ();
   gpx_rsp_if   rsp_bus ();

   int unsigned mismatch_count;
   int unsigned pending_beats;
   int unsigned checked_beats;

   // Per-kind count of request beats the block took, for the closing summary.
   int unsigned beats_sent [5] = '{default: 0};
   int unsigned beats_offered = 0;
   int unsigned rsp_taken = 0;

   // Remaining beats of a no-idle stretch, one counter per side.
   int          send_calm = 0;
   int          take_calm = 0;

   // Pin levels last driven on a pin event.
   logic [15:0] pins_now = ALL_ONES;

   gpio_expander_register_block dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   gpx_register_checker status_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_beats  (pending_beats),
      .checked_beats  (checked_beats)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Draw the idle cycles before the next beat: half the time none, else 0..18.
   // Now and then start a stretch where this side never idles.
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0)
         calm = $urandom_range(8, 40);
      return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18);
   endfunction

   // Mostly real registers, sometimes any byte so the stop path is taken.
   function automatic logic [7:0] pick_register();
      return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 7))
                                        : 8'($urandom_range(0, 255));
   endfunction

   // Favor the all-zero and all-one bytes, which set every pin of a port alike.
   function automatic logic [7:0] pick_byte();
      int unsigned roll;
      roll = $urandom_range(0, 7);
      if (roll == 0)
         return 8'h00;
      if (roll == 1)
         return 8'hff;
      return 8'($urandom_range(0, 255));
   endfunction

   // Offer one request beat after a random gap and hold it until taken.
   // Leave at the falling edge after the handshake.
   task automatic send_beat(input kind_type kind, input logic [7:0] value,
                            input logic [15:0] levels);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= kind;
      req_bus.data_byte  <= value;
      req_bus.pin_levels <= levels;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      beats_sent[kind]++;
      beats_offered++;
   endtask

   // Unused payload fields carry random values; the block must ignore them.
   task automatic bus_command(input logic [7:0] target);
      send_beat(KIND_CMD, target, 16'($urandom_range(0, 65535)));
   endtask

   task automatic bus_write(input logic [7:0] value);
      send_beat(KIND_WRITE, value, 16'($urandom_range(0, 65535)));
   endtask

   task automatic bus_read();
      send_beat(KIND_READ, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
   endtask

   task automatic pin_change(input logic [15:0] levels);
      pins_now = levels;
      send_beat(KIND_PINS, 8'($urandom_range(0, 255)), levels);
   endtask

   task automatic reset_pin();
      send_beat(KIND_RESET_PIN, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
   endtask

   // Response side: draw a stall per beat, take whatever comes.
   initial begin : response_taker
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = draw_gap(take_calm);
         // Hold off long enough that the block backs up and refuses requests.
         if (rsp_taken == 200 || rsp_taken == 900)
            stall = 64;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         rsp_taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [15:0] held_pins;
      logic [15:0] flip_mask;
      int unsigned next_drain;
      int unsigned roll;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.kind       = KIND_CMD;
      req_bus.data_byte  = 8'h00;
      req_bus.pin_levels = ALL_ONES;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Reset contents, pointer flipping inside the input pair.
      bus_read();
      bus_read();
      // Command naming no register: later data is dropped, reads return nothing.
      bus_command(8'hff);
      bus_write(8'h5a);
      bus_read();
      // Writes into an input register are refused and stop the transfer.
      bus_command(8'(REG_IN1));
      bus_write(8'h00);
      bus_write(8'h00);
      // Turn all of port 0 and half of port 1 into outputs.
      bus_command(8'(REG_CONF0));
      bus_write(8'h00);
      bus_write(8'hf0);
      // Output writes copy changed bits of output pins into the input registers.
      bus_command(8'(REG_OUT0));
      bus_write(8'h00);
      bus_write(8'ha5);
      // Several input pins at once, then the reset pin with low external levels.
      pin_change(16'h0000);
      reset_pin();
      // One port 1 pin raises the interrupt, returning to the snapshot drops it.
      pin_change(16'h0100);
      pin_change(16'h0000);
      // A port 0 pin raises it again; reading port 1 keeps it, port 0 drops it.
      pin_change(16'h0001);
      bus_command(8'(REG_INV0));
      bus_write(8'hff);
      bus_write(8'h00);
      bus_command(8'(REG_IN1));
      bus_read();
      bus_read();

      // Random traffic: mostly complete transfers with random content,
      // glitches on the pins, and a little noise.
      next_drain = 500;
      while (beats_offered < 1550) begin
         // Pause the sender now and then until every response is back.
         if (beats_offered >= next_drain) begin
            req_bus.valid <= 1'b0;
            while (pending_beats != 0) @(negedge clock);
            next_drain += 500;
         end
         roll = $urandom_range(0, 99);
         if (roll < 30) begin
            bus_command(pick_register());
            repeat ($urandom_range(1, 3)) bus_write(pick_byte());
         end else if (roll < 55) begin
            bus_command(pick_register());
            repeat ($urandom_range(1, 4)) bus_read();
         end else if (roll < 62) begin
            if ($urandom_range(0, 1) == 0)
               bus_read();
            else
               bus_write(pick_byte());
         end else if (roll < 82) begin
            // Flip a few pins, maybe read the inputs, then usually flip back.
            held_pins = pins_now;
            flip_mask = ALL_ZEROES;
            repeat ($urandom_range(1, 3)) flip_mask[$urandom_range(0, 15)] = 1'b1;
            pin_change(held_pins ^ flip_mask);
            if ($urandom_range(0, 1) == 0) begin
               bus_command($urandom_range(0, 1) ? 8'(REG_IN1) : 8'(REG_IN0));
               bus_read();
            end
            if ($urandom_range(0, 9) < 7)
               pin_change(held_pins);
         end else if (roll < 94) begin
            pin_change(16'($urandom_range(0, 65535)));
         end else if (roll < 97) begin
            reset_pin();
         end else begin
            bus_command(pick_register());
         end
      end
      req_bus.valid <= 1'b0;

      // Drain, then let the pipeline run on idle to show any stray beat.
      while (pending_beats != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Covered %0d command, %0d write, %0d read, %0d pin and %0d reset-pin beats,",
               beats_sent[KIND_CMD], beats_sent[KIND_WRITE], beats_sent[KIND_READ],
               beats_sent[KIND_PINS], beats_sent[KIND_RESET_PIN]);
      $display("with two long response stalls; %0d responses checked, %0d mismatches.",
               checked_beats, mismatch_count);
      if (mismatch_count == 0 && pending_beats == 0) begin
         $display("gpio_expander_register_block test passed");
      end else begin
         $display("gpio_expander_register_block test failed");
      end
      $finish;
   end

   // Bound the run well beyond the slowest legal schedule.
   initial begin : watchdog
      #5ms;
      $display("Timed out with %0d responses outstanding", pending_beats);
      $display("gpio_expander_register_block test failed");
      $finish;
   end

endmodule

`default_nettype wire
